// ===== design/stps_pkg.sv =====
// Shared constants, types and helpers for the sphere-trace pixel shader core.
`default_nettype none
package stps_pkg;

    // Fixed-point format: signed Q8.16 in 24 bits.
    localparam int FRAC_BITS = 16;
    localparam int FX_W      = 24;
    localparam logic signed [53:0] FX_MAX_W = 54'sd8388607;
    localparam logic signed [53:0] FX_MIN_W = -54'sd8388608;
    localparam logic signed [53:0] FX_ONE_W = 54'sd65536;
    localparam logic signed [53:0] FX_TWO_W = 54'sd131072;
    // Hit threshold, 0.01 rounded to the fixed-point grid.
    localparam logic signed [FX_W-1:0] HIT_THRESH = 24'sd655;

    // Datapath widths.
    localparam int MUL_W     = 26;
    localparam int PROD_W    = 52;
    localparam int DIV_N_W   = 41;
    localparam int DIV_D_W   = 26;
    localparam int SQ_N_W    = 52;
    localparam int SQ_R_W    = 26;
    localparam int SQ_REM_W  = 28;
    localparam int DIV_STEPS = 41;
    localparam int SQ_STEPS  = 26;

    // Configuration register indexes.
    localparam logic [2:0] CFG_SCREEN_W = 3'd0;
    localparam logic [2:0] CFG_SCREEN_H = 3'd1;
    localparam logic [2:0] CFG_PLATE_W  = 3'd2;
    localparam logic [2:0] CFG_PLATE_H  = 3'd3;
    localparam logic [2:0] CFG_FOCUS    = 3'd4;
    localparam logic [2:0] CFG_NEAR     = 3'd5;
    localparam logic [2:0] CFG_MARCHES  = 3'd6;

    // What a finished division is used for.
    typedef enum logic [2:0] {
        DT_PX, DT_PY, DT_UX, DT_UY, DT_UZ, DT_LIGHT
    } div_tag_t;

    // What a finished square root is used for.
    typedef enum logic [1:0] {
        QT_LEN, QT_DIST0, QT_DIST, QT_LIGHT
    } sq_tag_t;

    // Saturate a wide signed value to the 24-bit fixed-point range.
    function automatic logic signed [FX_W-1:0] sat_fx(input logic signed [53:0] v);
        logic signed [FX_W-1:0] r;
        if (v > FX_MAX_W) begin
            r = 24'sd8388607;
        end else if (v < FX_MIN_W) begin
            r = -24'sd8388608;
        end else begin
            r = v[FX_W-1:0];
        end
        return r;
    endfunction

endpackage
`default_nettype wire

// ===== design/sphere_trace_pixel_shader_core.sv =====
// Sphere-trace pixel shader: one shared multiplier, divider and square-root unit.
// A pixel is traced from accept to output valid through the march steps that it takes,
// with a shading pass on a hit; a degenerate ray skips its three divisions.
// A vector length is three squares, 26 root digits and a finishing step; each march
// step is three multiplies and one vector length.
// Throughput: one pixel at a time; a new word is taken once the last result is in the
// output register, where it waits for the receiver while the next pixel is traced.
// Reset (aresetn low, synchronous) empties the output and restores register defaults.
`default_nettype none
module sphere_trace_pixel_shader_core (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // [9:0] pixel_x, [19:10] pixel_y, [23:20] zero
    input  wire logic [23:0] s_axis_tdata,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // [9:0] out_x, [19:10] out_y, [20] hit, [28:21] red, [36:29] green, [39:37] zero
    output logic [39:0]      m_axis_tdata,
    input  wire logic        cfg_we,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [23:0] cfg_wdata
);
    import stps_pkg::*;

    typedef enum logic [15:0] {
        ST_IDLE = 16'b0000000000000001,
        ST_PMX  = 16'b0000000000000010,
        ST_PDX  = 16'b0000000000000100,
        ST_PMY  = 16'b0000000000001000,
        ST_PDY  = 16'b0000000000010000,
        ST_DIV  = 16'b0000000000100000,
        ST_SQA  = 16'b0000000001000000,
        ST_SQB  = 16'b0000000010000000,
        ST_SQC  = 16'b0000000100000000,
        ST_SQLD = 16'b0000001000000000,
        ST_SQRT = 16'b0000010000000000,
        ST_MX   = 16'b0000100000000000,
        ST_MY   = 16'b0001000000000000,
        ST_MZ   = 16'b0010000000000000,
        ST_MW   = 16'b0100000000000000,
        ST_FIN  = 16'b1000000000000000
    } state_t;

    state_t state_reg, state_next;

    // Configuration registers.
    logic [10:0]            sw_reg, sh_reg;
    logic [22:0]            pw_reg, ph_reg;
    logic signed [FX_W-1:0] fd_reg, no_reg;
    logic [7:0]             mm_reg;

    // Pixel and ray state.
    logic [9:0]             pix_x_reg, pix_y_reg;
    logic signed [FX_W-1:0] pos_x_reg, pos_y_reg, pos_z_reg, dist_reg;
    logic signed [24:0]     d_x_reg, d_y_reg, d_z_reg;
    logic signed [17:0]     u_x_reg, u_y_reg, u_z_reg;
    logic [7:0]             step_reg;
    logic                   hit_reg;
    logic [16:0]            inten_reg;

    // Multiplier and sum of squares.
    logic signed [PROD_W-1:0] prod_reg;
    logic [PROD_W-1:0]        acc_reg;
    logic signed [MUL_W-1:0]  mul_a, mul_b, comp_a, comp_b, comp_c;
    logic signed [PROD_W-1:0] mul_p;
    logic [PROD_W-1:0]        prod_abs;

    // Divider.
    logic [DIV_N_W-1:0] div_num_reg;
    logic [DIV_D_W-1:0] div_rem_reg, div_den_reg;
    logic [5:0]         div_cnt_reg;
    logic               div_neg_reg;
    div_tag_t           div_tag_reg;
    logic [DIV_D_W:0]   div_rem_sh, div_diff;
    logic               div_ge, div_done;
    logic signed [41:0] div_q_s;

    // Square root.
    logic [SQ_N_W-1:0]   sq_n_reg;
    logic [SQ_REM_W-1:0] sq_rem_reg;
    logic [SQ_R_W-1:0]   sq_root_reg;
    logic [4:0]          sq_cnt_reg;
    sq_tag_t             sq_tag_reg;
    logic [29:0]         sq_rem_sh, sq_trial, sq_diff;
    logic                sq_ge, sq_done;

    logic [10:0]            sw_eff, sh_eff;
    logic signed [11:0]     diff_x, diff_y;
    logic signed [FX_W-1:0] oz_calc, wz_calc, dist_new;
    logic                   dist_hit;
    logic [24:0]            abs_dx, abs_dy, abs_dz;
    logic                   out_free;
    logic [24:0]            red_prod, green_prod;

    // Screen setup and ray origin.
    assign sw_eff  = (sw_reg == 11'd0) ? 11'd1 : sw_reg;
    assign sh_eff  = (sh_reg == 11'd0) ? 11'd1 : sh_reg;
    assign diff_x  = $signed({2'b00, pix_x_reg}) - $signed({2'b00, sw_eff[10:1]});
    assign diff_y  = $signed({2'b00, sh_eff[10:1]}) - $signed({2'b00, pix_y_reg});
    assign oz_calc = sat_fx(54'(fd_reg) - FX_TWO_W);
    assign wz_calc = sat_fx(54'(no_reg) - FX_TWO_W);

    assign abs_dx = d_x_reg[24] ? 25'(-d_x_reg) : 25'(d_x_reg);
    assign abs_dy = d_y_reg[24] ? 25'(-d_y_reg) : 25'(d_y_reg);
    assign abs_dz = d_z_reg[24] ? 25'(-d_z_reg) : 25'(d_z_reg);
    assign prod_abs = prod_reg[PROD_W-1] ? 52'(-prod_reg) : 52'(prod_reg);

    // Vector components for the current length computation.
    always_comb begin
        case (sq_tag_reg)
            QT_LEN: begin
                comp_a = 26'(d_x_reg);
                comp_b = 26'(d_y_reg);
                comp_c = 26'(d_z_reg);
            end
            QT_LIGHT: begin
                comp_a = 26'sd131072 - 26'(pos_x_reg);
                comp_b = 26'sd65536 - 26'(pos_y_reg);
                comp_c = -26'(pos_z_reg);
            end
            default: begin
                comp_a = 26'(pos_x_reg);
                comp_b = 26'(pos_y_reg);
                comp_c = 26'(pos_z_reg);
            end
        endcase
    end

    // Shared multiplier operand selection.
    always_comb begin
        case (state_reg)
            ST_PMX: begin
                mul_a = 26'(diff_x);
                mul_b = $signed({3'b000, pw_reg});
            end
            ST_PMY: begin
                mul_a = 26'(diff_y);
                mul_b = $signed({3'b000, ph_reg});
            end
            ST_SQA: begin
                mul_a = comp_a;
                mul_b = comp_a;
            end
            ST_SQB: begin
                mul_a = comp_b;
                mul_b = comp_b;
            end
            ST_SQC: begin
                mul_a = comp_c;
                mul_b = comp_c;
            end
            ST_MX: begin
                mul_a = 26'(u_x_reg);
                mul_b = 26'(dist_reg);
            end
            ST_MY: begin
                mul_a = 26'(u_y_reg);
                mul_b = 26'(dist_reg);
            end
            ST_MZ: begin
                mul_a = 26'(u_z_reg);
                mul_b = 26'(dist_reg);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end
    assign mul_p = mul_a * mul_b;

    // One restoring division step per cycle.
    assign div_rem_sh = {div_rem_reg, div_num_reg[DIV_N_W-1]};
    assign div_ge     = div_rem_sh >= {1'b0, div_den_reg};
    assign div_diff   = div_rem_sh - {1'b0, div_den_reg};
    assign div_done   = (div_cnt_reg == 6'd0);
    assign div_q_s    = div_neg_reg ? -$signed({1'b0, div_num_reg})
                                    : $signed({1'b0, div_num_reg});

    // One square-root digit per cycle.
    assign sq_rem_sh = {sq_rem_reg, sq_n_reg[SQ_N_W-1 -: 2]};
    assign sq_trial  = {2'b00, sq_root_reg, 2'b01};
    assign sq_ge     = sq_rem_sh >= sq_trial;
    assign sq_diff   = sq_rem_sh - sq_trial;
    assign sq_done   = (sq_cnt_reg == 5'd0);

    assign dist_new = sat_fx($signed(54'(sq_root_reg)) - FX_ONE_W);
    assign dist_hit = dist_new <= HIT_THRESH;

    assign out_free      = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = (state_reg == ST_IDLE);

    assign red_prod   = 25'(inten_reg) * 25'd255;
    assign green_prod = 25'(inten_reg) * 25'd165;

    // Sequencer.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_axis_tvalid) state_next = ST_PMX;
            end
            ST_PMX: state_next = ST_PDX;
            ST_PDX: state_next = ST_DIV;
            ST_PMY: state_next = ST_PDY;
            ST_PDY: state_next = ST_DIV;
            ST_DIV: begin
                if (div_done) begin
                    case (div_tag_reg)
                        DT_PX:    state_next = ST_PMY;
                        DT_PY:    state_next = ST_SQA;
                        DT_UZ:    state_next = ST_SQA;
                        DT_LIGHT: state_next = ST_FIN;
                        default:  state_next = ST_DIV;
                    endcase
                end
            end
            ST_SQA:  state_next = ST_SQB;
            ST_SQB:  state_next = ST_SQC;
            ST_SQC:  state_next = ST_SQLD;
            ST_SQLD: state_next = ST_SQRT;
            ST_SQRT: begin
                if (sq_done) begin
                    case (sq_tag_reg)
                        QT_LEN:   state_next = (sq_root_reg == '0) ? ST_SQA : ST_DIV;
                        QT_DIST0: state_next = (mm_reg == 8'd0) ? ST_FIN : ST_MX;
                        QT_DIST: begin
                            if (dist_hit) begin
                                state_next = ST_SQA;
                            end else if (step_reg == mm_reg) begin
                                state_next = ST_FIN;
                            end else begin
                                state_next = ST_MX;
                            end
                        end
                        default:  state_next = ST_DIV;
                    endcase
                end
            end
            ST_MX: state_next = ST_MY;
            ST_MY: state_next = ST_MZ;
            ST_MZ: state_next = ST_MW;
            ST_MW: state_next = ST_SQA;
            ST_FIN: begin
                if (out_free) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Control state, configuration and output valid.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            m_axis_tvalid <= 1'b0;
            div_cnt_reg   <= '0;
            sq_cnt_reg    <= '0;
            sw_reg        <= 11'd640;
            sh_reg        <= 11'd480;
            pw_reg        <= 23'd65536;
            ph_reg        <= 23'd65536;
            fd_reg        <= 24'sd65536;
            no_reg        <= 24'sd65536;
            mm_reg        <= 8'd64;
        end else begin
            state_reg <= state_next;
            if (cfg_we) begin
                case (cfg_index)
                    CFG_SCREEN_W: sw_reg <= cfg_wdata[10:0];
                    CFG_SCREEN_H: sh_reg <= cfg_wdata[10:0];
                    CFG_PLATE_W:  pw_reg <= cfg_wdata[22:0];
                    CFG_PLATE_H:  ph_reg <= cfg_wdata[22:0];
                    CFG_FOCUS:    fd_reg <= $signed(cfg_wdata);
                    CFG_NEAR:     no_reg <= $signed(cfg_wdata);
                    CFG_MARCHES:  mm_reg <= cfg_wdata[7:0];
                    default: ;
                endcase
            end
            if (state_reg == ST_FIN && out_free) begin
                m_axis_tvalid <= 1'b1;
            end else if (m_axis_tready) begin
                m_axis_tvalid <= 1'b0;
            end
            // Counters of the shared units.
            if (state_reg == ST_PDX || state_reg == ST_PDY) begin
                div_cnt_reg <= 6'(DIV_STEPS);
            end else if (state_reg == ST_DIV && div_done &&
                         (div_tag_reg == DT_UX || div_tag_reg == DT_UY)) begin
                div_cnt_reg <= 6'(DIV_STEPS);
            end else if (state_reg == ST_SQRT && sq_done &&
                         ((sq_tag_reg == QT_LEN && sq_root_reg != '0) ||
                          sq_tag_reg == QT_LIGHT)) begin
                div_cnt_reg <= 6'(DIV_STEPS);
            end else if (state_reg == ST_DIV && !div_done) begin
                div_cnt_reg <= div_cnt_reg - 6'd1;
            end
            if (state_reg == ST_SQLD) begin
                sq_cnt_reg <= 5'(SQ_STEPS);
            end else if (state_reg == ST_SQRT && !sq_done) begin
                sq_cnt_reg <= sq_cnt_reg - 5'd1;
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge aclk) begin
        case (state_reg)
            ST_IDLE: begin
                if (s_axis_tvalid) begin
                    pix_x_reg <= s_axis_tdata[9:0];
                    pix_y_reg <= s_axis_tdata[19:10];
                    pos_x_reg <= '0;
                    pos_y_reg <= '0;
                    pos_z_reg <= oz_calc;
                end
            end
            ST_PMX, ST_PMY, ST_SQA: prod_reg <= mul_p;
            ST_PDX, ST_PDY: begin
                div_num_reg <= prod_abs[DIV_N_W-1:0];
                div_den_reg <= (state_reg == ST_PDX) ? 26'(sw_eff) : 26'(sh_eff);
                div_neg_reg <= prod_reg[PROD_W-1];
                div_rem_reg <= '0;
                div_tag_reg <= (state_reg == ST_PDX) ? DT_PX : DT_PY;
            end
            ST_DIV: begin
                if (!div_done) begin
                    div_rem_reg <= div_ge ? div_diff[DIV_D_W-1:0] : div_rem_sh[DIV_D_W-1:0];
                    div_num_reg <= {div_num_reg[DIV_N_W-2:0], div_ge};
                end else begin
                    case (div_tag_reg)
                        DT_PX: d_x_reg <= 25'(sat_fx(54'(div_q_s)));
                        DT_PY: begin
                            d_y_reg    <= 25'(sat_fx(54'(div_q_s)));
                            d_z_reg    <= 25'(wz_calc) - 25'(pos_z_reg);
                            sq_tag_reg <= QT_LEN;
                        end
                        DT_UX: begin
                            u_x_reg     <= div_q_s[17:0];
                            div_num_reg <= {abs_dy, 16'b0};
                            div_neg_reg <= d_y_reg[24];
                            div_rem_reg <= '0;
                            div_tag_reg <= DT_UY;
                        end
                        DT_UY: begin
                            u_y_reg     <= div_q_s[17:0];
                            div_num_reg <= {abs_dz, 16'b0};
                            div_neg_reg <= d_z_reg[24];
                            div_rem_reg <= '0;
                            div_tag_reg <= DT_UZ;
                        end
                        DT_UZ: begin
                            u_z_reg    <= div_q_s[17:0];
                            sq_tag_reg <= QT_DIST0;
                            step_reg   <= '0;
                        end
                        DT_LIGHT: begin
                            hit_reg   <= 1'b1;
                            inten_reg <= (div_num_reg > 41'd65536) ? 17'd0
                                         : 17'd65536 - div_num_reg[16:0];
                        end
                        default: ;
                    endcase
                end
            end
            ST_SQB: begin
                acc_reg  <= 52'(prod_reg);
                prod_reg <= mul_p;
            end
            ST_SQC: begin
                acc_reg  <= acc_reg + 52'(prod_reg);
                prod_reg <= mul_p;
            end
            ST_SQLD: begin
                sq_n_reg    <= acc_reg + 52'(prod_reg);
                sq_rem_reg  <= '0;
                sq_root_reg <= '0;
            end
            ST_SQRT: begin
                if (!sq_done) begin
                    sq_rem_reg  <= sq_ge ? sq_diff[SQ_REM_W-1:0] : sq_rem_sh[SQ_REM_W-1:0];
                    sq_root_reg <= {sq_root_reg[SQ_R_W-2:0], sq_ge};
                    sq_n_reg    <= {sq_n_reg[SQ_N_W-3:0], 2'b00};
                end else begin
                    case (sq_tag_reg)
                        QT_LEN: begin
                            if (sq_root_reg == '0) begin
                                // Degenerate ray: it stays at its origin.
                                u_x_reg    <= '0;
                                u_y_reg    <= '0;
                                u_z_reg    <= '0;
                                sq_tag_reg <= QT_DIST0;
                                step_reg   <= '0;
                            end else begin
                                div_num_reg <= {abs_dx, 16'b0};
                                div_den_reg <= sq_root_reg;
                                div_neg_reg <= d_x_reg[24];
                                div_rem_reg <= '0;
                                div_tag_reg <= DT_UX;
                            end
                        end
                        QT_DIST0: begin
                            dist_reg  <= dist_new;
                            hit_reg   <= 1'b0;
                            inten_reg <= '0;
                        end
                        QT_DIST: begin
                            dist_reg <= dist_new;
                            if (dist_hit) begin
                                sq_tag_reg <= QT_LIGHT;
                            end else begin
                                hit_reg   <= 1'b0;
                                inten_reg <= '0;
                            end
                        end
                        default: begin
                            div_num_reg <= 41'(sq_root_reg);
                            div_den_reg <= 26'd3;
                            div_neg_reg <= 1'b0;
                            div_rem_reg <= '0;
                            div_tag_reg <= DT_LIGHT;
                        end
                    endcase
                end
            end
            ST_MX: prod_reg <= mul_p;
            ST_MY: begin
                pos_x_reg <= sat_fx(54'(pos_x_reg) + 54'(prod_reg >>> FRAC_BITS));
                prod_reg  <= mul_p;
            end
            ST_MZ: begin
                pos_y_reg <= sat_fx(54'(pos_y_reg) + 54'(prod_reg >>> FRAC_BITS));
                prod_reg  <= mul_p;
            end
            ST_MW: begin
                pos_z_reg  <= sat_fx(54'(pos_z_reg) + 54'(prod_reg >>> FRAC_BITS));
                step_reg   <= step_reg + 8'd1;
                sq_tag_reg <= QT_DIST;
            end
            ST_FIN: begin
                if (out_free) begin
                    m_axis_tdata <= {3'b000, green_prod[23:16], red_prod[23:16], hit_reg,
                                     pix_y_reg, pix_x_reg};
                end
            end
            default: ;
        endcase
    end

`ifndef SYNTHESIS
    // A word taken closes the input until the pixel is finished.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("input accepted again while a pixel is in flight");

    // A new output word only comes from the finishing state.
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_axis_tvalid) |-> $past(state_reg == ST_FIN))
        else $error("output word raised outside the finishing state");

    // A miss is always black.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && !m_axis_tdata[20]) |->
        (m_axis_tdata[28:21] == 8'd0 && m_axis_tdata[36:29] == 8'd0))
        else $error("miss with nonzero color");

    // The divider only runs while the sequencer waits on it.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (div_cnt_reg != 6'd0) |-> (state_reg == ST_DIV))
        else $error("divider busy outside the division state");
`endif

endmodule
`default_nettype wire

// ===== dv/sphere_trace_pixel_shader_core_checker.sv =====
// Checker for the sphere-trace pixel shader: predicts each shaded pixel and compares.
`default_nettype none
module sphere_trace_pixel_shader_core_checker (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_axis_tvalid,
    input  wire logic        s_axis_tready,
    input  wire logic [23:0] s_axis_tdata,
    input  wire logic        m_axis_tvalid,
    input  wire logic        m_axis_tready,
    input  wire logic [39:0] m_axis_tdata,
    input  wire logic        cfg_we,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [23:0] cfg_wdata,
    output int               fail_count,
    output int               pending_count
);
    import stps_pkg::*;

    localparam longint ONE = 64'sd65536;
    localparam longint SMAX = 64'sd8388607;
    localparam longint SMIN = -64'sd8388608;

    typedef struct packed {
        logic [7:0] green;
        logic [7:0] red;
        logic       hit;
        logic [9:0] y;
        logic [9:0] x;
    } pixel_color_t;

    pixel_color_t expected_colors[$];

    logic [10:0] scr_w, scr_h;
    logic [22:0] plt_w, plt_h;
    logic signed [23:0] focus, near;
    logic [7:0] marches;

    function automatic longint clamp_fx(longint v);
        if (v > SMAX) return SMAX;
        if (v < SMIN) return SMIN;
        return v;
    endfunction

    function automatic longint floor_fx(longint v);
        return v >>> FRAC_BITS;
    endfunction

    function automatic longint int_sqrt(longint unsigned n);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > n) b = b >> 2;
        while (b != 0) begin
            if (n >= r + b) begin
                n = n - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return longint'(r);
    endfunction

    function automatic longint norm3(longint a, longint b, longint c);
        return int_sqrt(longint'(a * a) + longint'(b * b) + longint'(c * c));
    endfunction

    // Trace one pixel and shade it.
    function automatic pixel_color_t shade_pixel(logic [9:0] px_in, logic [9:0] py_in);
        pixel_color_t r;
        longint px, py, sw, sh, oz, wx, wy, wz, dx, dy, dz, len, ux, uy, uz;
        longint qx, qy, qz, surf_dist, ll, inten;
        px = px_in;
        py = py_in;
        sw = (scr_w == 0) ? 1 : scr_w;
        sh = (scr_h == 0) ? 1 : scr_h;
        r = '0;
        r.x = px_in;
        r.y = py_in;
        oz = clamp_fx(-2 * ONE + longint'(focus));
        wx = clamp_fx((px - sw / 2) * longint'(plt_w) / sw);
        wy = clamp_fx((sh / 2 - py) * longint'(plt_h) / sh);
        wz = clamp_fx(-2 * ONE + longint'(near));
        dx = wx;
        dy = wy;
        dz = wz - oz;
        len = norm3(dx, dy, dz);
        if (len != 0) begin
            ux = dx * ONE / len;
            uy = dy * ONE / len;
            uz = dz * ONE / len;
        end else begin
            ux = 0; uy = 0; uz = 0;
        end
        qx = 0; qy = 0; qz = oz;
        surf_dist = clamp_fx(norm3(qx, qy, qz) - ONE);
        for (int i = 0; i < marches; i++) begin
            qx = clamp_fx(qx + floor_fx(ux * surf_dist));
            qy = clamp_fx(qy + floor_fx(uy * surf_dist));
            qz = clamp_fx(qz + floor_fx(uz * surf_dist));
            surf_dist = clamp_fx(norm3(qx, qy, qz) - ONE);
            if (surf_dist <= longint'(HIT_THRESH)) begin
                ll = norm3(2 * ONE - qx, ONE - qy, -qz);
                inten = ONE - ll / 3;
                if (inten < 0) inten = 0;
                r.hit = 1'b1;
                r.red = 8'((255 * inten) >> FRAC_BITS);
                r.green = 8'((165 * inten) >> FRAC_BITS);
                break;
            end
        end
        return r;
    endfunction

    assign pending_count = expected_colors.size();

    // Track registers, predict on accepted inputs, compare on accepted outputs.
    always @(posedge aclk) begin
        pixel_color_t want, got;
        if (!aresetn) begin
            scr_w <= 11'd640; scr_h <= 11'd480;
            plt_w <= 23'd65536; plt_h <= 23'd65536;
            focus <= 24'sd65536; near <= 24'sd65536;
            marches <= 8'd64;
            expected_colors.delete();
            fail_count <= 0;
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    CFG_SCREEN_W: scr_w <= cfg_wdata[10:0];
                    CFG_SCREEN_H: scr_h <= cfg_wdata[10:0];
                    CFG_PLATE_W:  plt_w <= cfg_wdata[22:0];
                    CFG_PLATE_H:  plt_h <= cfg_wdata[22:0];
                    CFG_FOCUS:    focus <= cfg_wdata;
                    CFG_NEAR:     near <= cfg_wdata;
                    CFG_MARCHES:  marches <= cfg_wdata[7:0];
                    default: ;
                endcase
            end
            if (s_axis_tvalid && s_axis_tready)
                expected_colors.push_back(shade_pixel(s_axis_tdata[9:0], s_axis_tdata[19:10]));
            if (m_axis_tvalid && m_axis_tready) begin
                got = m_axis_tdata[36:0];
                if (expected_colors.size() == 0) begin
                    $display("%0t: unexpected word, actual %h", $time, got);
                    fail_count <= fail_count + 1;
                end else begin
                    want = expected_colors.pop_front();
                    if (want !== got || m_axis_tdata[39:37] !== 3'b0) begin
                        $display({"%0t: mismatch x/y/hit/red/green expected %0d %0d %0d %0d %0d",
                                  " actual %0d %0d %0d %0d %0d"},
                            $time, want.x, want.y, want.hit, want.red, want.green,
                            got.x, got.y, got.hit, got.red, got.green);
                        fail_count <= fail_count + 1;
                    end
                end
            end
        end
    end
endmodule
`default_nettype wire

// ===== dv/sphere_trace_pixel_shader_core_test.sv =====
// Testbench top for the sphere-trace pixel shader: stimulus, register phases and verdict.
`default_nettype none
module sphere_trace_pixel_shader_core_test;
    import stps_pkg::*;

    logic        aclk;
    logic        aresetn;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [39:0] m_axis_tdata;
    logic        cfg_we;
    logic [2:0]  cfg_index;
    logic [23:0] cfg_wdata;
    int          fail_count;
    int          pending_count;
    bit          hold_off;

    sphere_trace_pixel_shader_core DUT (.*);

    sphere_trace_pixel_shader_core_checker checker_inst (.*);

    initial begin
        aclk = 0;
        forever #5 aclk = ~aclk;
    end

    // Receiver stall pattern, with long hold-offs on request.
    initial begin
        int mode;
        m_axis_tready = 0;
        forever begin
            @(posedge aclk);
            mode = $urandom_range(0, 3);
            if (hold_off) begin
                m_axis_tready <= 0;
                repeat (3000) @(posedge aclk);
                hold_off = 0;
            end else if (mode == 0) begin
                m_axis_tready <= 1;
            end else begin
                m_axis_tready <= ($urandom_range(0, 2) != 0);
            end
        end
    end

    // One register write; the enable drops for a cycle before the next write.
    task automatic write_reg(logic [2:0] idx, logic [23:0] val);
        cfg_we <= 1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_we <= 0;
        @(posedge aclk);
    endtask

    // Offer one pixel word and wait for it to be taken; gaps between bursts.
    int burst_left;
    task automatic send_pixel(logic [9:0] x, logic [9:0] y);
        if (burst_left == 0) begin
            s_axis_tvalid <= 0;
            repeat ($urandom_range(1, 400)) @(posedge aclk);
            burst_left = $urandom_range(1, 8);
        end
        s_axis_tvalid <= 1;
        s_axis_tdata <= {4'b0, y, x};
        @(posedge aclk);
        while (!s_axis_tready) @(posedge aclk);
        burst_left--;
    endtask

    task automatic drain();
        s_axis_tvalid <= 0;
        while (pending_count != 0) @(posedge aclk);
        repeat (1200) @(posedge aclk);
    endtask

    task automatic random_pixels(int n, int wmax, int hmax);
        repeat (n) begin
            if ($urandom_range(0, 9) == 0)
                send_pixel(10'($urandom), 10'($urandom));
            else
                send_pixel(10'($urandom_range(0, wmax - 1)), 10'($urandom_range(0, hmax - 1)));
        end
    endtask

    initial begin
        s_axis_tvalid = 0;
        s_axis_tdata = 0;
        cfg_we = 0;
        cfg_index = 0;
        cfg_wdata = 0;
        hold_off = 0;
        burst_left = 0;
        aresetn = 0;
        repeat (6) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);

        // Directed: defaults, corners, center and out-of-screen pixels.
        send_pixel(10'd0, 10'd0);
        send_pixel(10'd320, 10'd240);
        send_pixel(10'd639, 10'd479);
        send_pixel(10'd1023, 10'd1023);
        send_pixel(10'd0, 10'd1023);
        send_pixel(10'd1023, 10'd0);
        send_pixel(10'd330, 10'd235);
        send_pixel(10'h2AA, 10'h155);
        send_pixel(10'h155, 10'h2AA);
        drain();

        // Zero-size screen with a zero step limit, then with the largest step limit.
        write_reg(CFG_SCREEN_W, 24'd0);
        write_reg(CFG_SCREEN_H, 24'd0);
        write_reg(CFG_MARCHES, 24'd0);
        send_pixel(10'd0, 10'd0);
        send_pixel(10'd5, 10'd3);
        drain();
        write_reg(CFG_MARCHES, 24'd255);
        send_pixel(10'd0, 10'd0);
        drain();
        // Degenerate ray: origin and plate point coincide at the center.
        write_reg(CFG_SCREEN_W, 24'd1);
        write_reg(CFG_SCREEN_H, 24'd1);
        write_reg(CFG_FOCUS, 24'd65536);
        write_reg(CFG_NEAR, 24'd65536);
        send_pixel(10'd0, 10'd0);
        send_pixel(10'd1, 10'd1);
        drain();

        // Extremes of the plate and offsets.
        write_reg(CFG_SCREEN_W, 24'd1024);
        write_reg(CFG_SCREEN_H, 24'd1024);
        write_reg(CFG_PLATE_W, 24'h7FFFFF);
        write_reg(CFG_PLATE_H, 24'd0);
        write_reg(CFG_FOCUS, 24'h800000);
        write_reg(CFG_NEAR, 24'h7FFFFF);
        write_reg(CFG_MARCHES, 24'd1);
        send_pixel(10'd0, 10'd0);
        send_pixel(10'd1023, 10'd1023);
        send_pixel(10'd512, 10'd512);
        drain();

        // Random phases, with a long receiver hold-off in the first.
        write_reg(CFG_SCREEN_W, 24'd640);
        write_reg(CFG_SCREEN_H, 24'd480);
        write_reg(CFG_PLATE_W, 24'd65536);
        write_reg(CFG_PLATE_H, 24'd65536);
        write_reg(CFG_FOCUS, 24'd65536);
        write_reg(CFG_NEAR, 24'd65536);
        write_reg(CFG_MARCHES, 24'd64);
        hold_off = 1;
        random_pixels(120, 640, 480);
        drain();
        for (int ph = 0; ph < 6; ph++) begin
            int w, h;
            w = $urandom_range(1, 1024);
            h = $urandom_range(1, 1024);
            write_reg(CFG_SCREEN_W, 24'(w));
            write_reg(CFG_SCREEN_H, 24'(h));
            write_reg(CFG_PLATE_W, 24'($urandom_range(16384, 262144)));
            write_reg(CFG_PLATE_H, (ph == 5) ? 24'h7FFFFF
                                             : 24'($urandom_range(16384, 262144)));
            write_reg(CFG_FOCUS, (ph == 4) ? 24'($urandom) : 24'($urandom_range(0, 131072)));
            write_reg(CFG_NEAR, (ph == 4) ? 24'($urandom)
                                          : 24'($urandom_range(65536, 196608)));
            write_reg(CFG_MARCHES, (ph == 3) ? 24'd255 : 24'($urandom_range(1, 80)));
            random_pixels(50, w, h);
            drain();
        end

        if (fail_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    initial begin
        #500000000;
        $display("FAIL");
        $finish;
    end
endmodule
`default_nettype wire

// ===== files.f =====
design/stps_pkg.sv
design/sphere_trace_pixel_shader_core.sv
dv/sphere_trace_pixel_shader_core_checker.sv
dv/sphere_trace_pixel_shader_core_test.sv
